>>> hdl/lzfd_pkg.sv
package lzfd_pkg;

  // History window size (bytes)
  localparam int HISTORY_DEPTH = 16384;

  // Token layout
  localparam int          DIST_BITS = 14;
  localparam logic [13:0] DIST_MASK = 14'h3FFF;
  localparam int          DIST_W    = 15;
  localparam int          LEN_W     = 6;
  localparam logic [5:0]  MIN_MATCH = 6'd3;

  // Flags carried by one flag word
  localparam logic [4:0] FLAGS_PER_WORD = 5'd30;

  // Command queue between parser and copy engine
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic {
    CMD_LIT,
    CMD_MATCH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [7:0]          lit;
    logic [DIST_W-1:0]   match_dist;
    logic [LEN_W-1:0]    len;
  } cmd_t;

endpackage

>>> hdl/lzfd_front.sv
module lzfd_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [7:0]         in_byte,
  output logic               in_stall,
  input  logic               q_full,
  output logic               q_push,
  output lzfd_pkg::cmd_t     q_cmd
);

  typedef enum logic [1:0] {
    PH_FLAGS,
    PH_ITEM,
    PH_TOKEN
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [31:0] flag_word_r, flag_word_nxt;
  logic [4:0]  flags_left_r, flags_left_nxt;
  logic [1:0]  hdr_cnt_r, hdr_cnt_nxt;
  logic [7:0]  token_hi_r, token_hi_nxt;
  logic [1:0]  shrink_r, shrink_nxt;
  logic        accept;
  logic [15:0] token;
  logic [13:0] dist_field;
  logic [4:0]  flags_dec;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign token    = {token_hi_r, in_byte};
  assign flags_dec = flags_left_r - 5'd1;

  // Split the token: low bits are distance, upper bits are length
  assign dist_field = token[13:0] & (lzfd_pkg::DIST_MASK >> shrink_r);

  always_comb begin
    phase_nxt        = phase_r;
    flag_word_nxt    = flag_word_r;
    flags_left_nxt   = flags_left_r;
    hdr_cnt_nxt      = hdr_cnt_r;
    token_hi_nxt     = token_hi_r;
    shrink_nxt       = shrink_r;
    q_push           = 1'b0;
    q_cmd.kind       = lzfd_pkg::CMD_LIT;
    q_cmd.lit        = in_byte;
    q_cmd.match_dist = {1'b0, dist_field} + 15'd1;
    q_cmd.len        = 6'(token >> (lzfd_pkg::DIST_BITS - int'(shrink_r)))
                       + lzfd_pkg::MIN_MATCH;
    if (accept) begin
      unique case (phase_r)
        PH_FLAGS: begin
          // Collect the big-endian flag word
          flag_word_nxt = {flag_word_r[23:0], in_byte};
          hdr_cnt_nxt   = hdr_cnt_r + 2'd1;
          if (hdr_cnt_r == 2'd3) begin
            shrink_nxt     = in_byte[1:0];
            flags_left_nxt = lzfd_pkg::FLAGS_PER_WORD;
            phase_nxt      = PH_ITEM;
          end
        end
        PH_ITEM: begin
          if (!flag_word_r[31]) begin
            // Literal: queue it and advance to the next flag
            q_push         = 1'b1;
            flag_word_nxt  = {flag_word_r[30:0], 1'b0};
            flags_left_nxt = flags_dec;
            phase_nxt      = (flags_dec == 5'd0) ? PH_FLAGS : PH_ITEM;
          end else begin
            token_hi_nxt = in_byte;
            phase_nxt    = PH_TOKEN;
          end
        end
        PH_TOKEN: begin
          // Match token complete: queue it and advance to the next flag
          q_push         = 1'b1;
          q_cmd.kind     = lzfd_pkg::CMD_MATCH;
          flag_word_nxt  = {flag_word_r[30:0], 1'b0};
          flags_left_nxt = flags_dec;
          phase_nxt      = (flags_dec == 5'd0) ? PH_FLAGS : PH_ITEM;
        end
        default: begin
          phase_nxt = PH_FLAGS;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_FLAGS;
      flag_word_r  <= '0;
      flags_left_r <= '0;
      hdr_cnt_r    <= '0;
      token_hi_r   <= '0;
      shrink_r     <= '0;
    end else begin
      phase_r      <= phase_nxt;
      flag_word_r  <= flag_word_nxt;
      flags_left_r <= flags_left_nxt;
      hdr_cnt_r    <= hdr_cnt_nxt;
      token_hi_r   <= token_hi_nxt;
      shrink_r     <= shrink_nxt;
    end
  end

  // Item phases always have a flag left to consume
  a_flags_in_item: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ITEM || phase_r == PH_TOKEN) |-> flags_left_r != 5'd0)
    else $error("item phase with no flag left");

  // Header counter only moves while collecting a flag word
  a_hdr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_FLAGS) |-> hdr_cnt_r == 2'd0)
    else $error("header count out of phase");

  // A token high byte never enqueues a command
  a_no_push_hi: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_ITEM && flag_word_r[31]) |-> !q_push)
    else $error("push on token high byte");

endmodule

>>> hdl/lzfd_queue.sv
module lzfd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  lzfd_pkg::cmd_t     push_cmd,
  input  logic               pop,
  output lzfd_pkg::cmd_t     pop_cmd,
  output logic               q_valid,
  output logic               q_full
);

  lzfd_pkg::cmd_t entries_r [lzfd_pkg::QUEUE_DEPTH];
  logic [lzfd_pkg::QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [lzfd_pkg::QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [lzfd_pkg::QPTR_W:0]   count_r, count_nxt;
  logic                        do_push, do_pop;

  assign q_valid = (count_r != '0);
  assign q_full  = (count_r == (lzfd_pkg::QPTR_W + 1)'(lzfd_pkg::QUEUE_DEPTH));
  assign pop_cmd = entries_r[rd_ptr_r];
  assign do_push = push && !q_full;
  assign do_pop  = pop && q_valid;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (lzfd_pkg::QPTR_W + 1)'(lzfd_pkg::QUEUE_DEPTH))
    else $error("queue occupancy exceeds depth");

  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("push into full queue");

endmodule

>>> hdl/lzfd_back.sv
module lzfd_back #(
  parameter int HISTORY_DEPTH = lzfd_pkg::HISTORY_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               q_valid,
  input  lzfd_pkg::cmd_t     q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_last_in_run,
  output logic               out_finished,
  output logic               out_bad_distance
);

  localparam int           AW      = $clog2(HISTORY_DEPTH);
  localparam logic [AW:0]  DEPTH_W = (AW + 1)'(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_A = AW'(HISTORY_DEPTH - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_COPY,
    S_STOP
  } state_t;

  state_t                    state_r, state_nxt;
  logic [31:0]               out_len_r, out_len_nxt;
  logic [31:0]               count_r, count_nxt;
  logic [AW-1:0]             wp_r, wp_nxt;
  logic [AW-1:0]             src_r, src_nxt;
  logic [lzfd_pkg::LEN_W-1:0] left_r, left_nxt;
  logic                      near_r, near_nxt;
  logic [7:0]                last_byte_r, last_byte_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [7:0]                out_byte_r, out_byte_nxt;
  logic                      out_last_r, out_last_nxt;
  logic                      out_fin_r, out_fin_nxt;
  logic                      out_bad_r, out_bad_nxt;

  logic [7:0]    mem [HISTORY_DEPTH];
  logic [7:0]    rd_data_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [7:0]    wr_byte;

  logic          out_free;
  logic [AW:0]   diff;
  logic [AW-1:0] src0;
  logic [31:0]   count_inc;
  logic          hit_len;
  logic [7:0]    copy_byte;

  assign out_free  = !out_valid_r || !out_stall;
  assign count_inc = count_r + 32'd1;
  assign hit_len   = (count_inc == out_len_r);
  assign copy_byte = near_r ? last_byte_r : rd_data_r;

  // Source address of the first match byte, wrapped into the window
  assign diff = {1'b0, wp_r} - (AW + 1)'(q_cmd.match_dist);
  assign src0 = diff[AW] ? AW'(diff + DEPTH_W) : diff[AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    out_len_nxt   = cfg_wr_en ? cfg_wr_data : out_len_r;
    count_nxt     = count_r;
    wp_nxt        = wp_r;
    src_nxt       = src_r;
    left_nxt      = left_r;
    near_nxt      = near_r;
    last_byte_nxt = last_byte_r;
    out_valid_nxt = out_free ? 1'b0 : out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_fin_nxt   = out_fin_r;
    out_bad_nxt   = out_bad_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = src_r;
    wr_en         = 1'b0;
    wr_byte       = q_cmd.lit;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          if (q_cmd.kind == lzfd_pkg::CMD_LIT) begin
            // Emit literal and record it in history
            wr_en         = 1'b1;
            wr_byte       = q_cmd.lit;
            out_valid_nxt = 1'b1;
            out_byte_nxt  = q_cmd.lit;
            out_last_nxt  = 1'b1;
            out_fin_nxt   = hit_len;
            out_bad_nxt   = 1'b0;
            if (hit_len) begin
              state_nxt = S_STOP;
            end
          end else if (32'(q_cmd.match_dist) > count_r) begin
            // Distance reaches before the first output: report and stop
            out_valid_nxt = 1'b1;
            out_byte_nxt  = 8'd0;
            out_last_nxt  = 1'b1;
            out_fin_nxt   = 1'b1;
            out_bad_nxt   = 1'b1;
            state_nxt     = S_STOP;
          end else begin
            // Start the copy: fetch the first source byte
            rd_en     = 1'b1;
            rd_addr   = src0;
            src_nxt   = (src0 == LAST_A) ? '0 : src0 + 1'b1;
            left_nxt  = q_cmd.len;
            near_nxt  = (q_cmd.match_dist == lzfd_pkg::DIST_W'(1));
            state_nxt = S_COPY;
          end
        end
      end
      S_COPY: begin
        if (out_free) begin
          // Emit one copied byte; fetch the next unless the run ends
          wr_en         = 1'b1;
          wr_byte       = copy_byte;
          left_nxt      = left_r - 1'b1;
          out_valid_nxt = 1'b1;
          out_byte_nxt  = copy_byte;
          out_last_nxt  = (left_r == lzfd_pkg::LEN_W'(1)) || hit_len;
          out_fin_nxt   = hit_len;
          out_bad_nxt   = 1'b0;
          if (hit_len) begin
            state_nxt = S_STOP;
          end else if (left_r == lzfd_pkg::LEN_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            rd_en   = 1'b1;
            rd_addr = src_r;
            src_nxt = (src_r == LAST_A) ? '0 : src_r + 1'b1;
          end
        end
      end
      S_STOP: begin
        // Drop everything after the stop
        q_pop = q_valid;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (wr_en) begin
      wp_nxt        = (wp_r == LAST_A) ? '0 : wp_r + 1'b1;
      count_nxt     = count_inc;
      last_byte_nxt = wr_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_len_r   <= 32'd1;
      count_r     <= '0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_len_r   <= out_len_nxt;
      count_r     <= count_nxt;
      wp_r        <= wp_nxt;
      out_valid_r <= out_valid_nxt;
    end
    src_r       <= src_nxt;
    left_r      <= left_nxt;
    near_r      <= near_nxt;
    last_byte_r <= last_byte_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    out_fin_r   <= out_fin_nxt;
    out_bad_r   <= out_bad_nxt;
  end

  // History RAM: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= wr_byte;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign out_valid        = out_valid_r;
  assign out_byte         = out_byte_r;
  assign out_last_in_run  = out_last_r;
  assign out_finished     = out_fin_r;
  assign out_bad_distance = out_bad_r;

  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STOP |=> state_r == S_STOP)
    else $error("left stop state without reset");

  a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_bad_r) |->
      (out_fin_r && out_last_r && out_byte_r == 8'd0))
    else $error("malformed error result");

  a_copy_left: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COPY |-> left_r != '0)
    else $error("copy with no bytes left");

  a_write_counts: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> count_r == $past(count_r) + 32'd1)
    else $error("produced count out of step with history writes");

endmodule

>>> hdl/lz_flag_word_decompressor.sv
// Channel  | Valid     | Stall     | Payload
// ---------+-----------+-----------+-----------------------------------------------
// in       | in_valid  | in_stall  | in_byte
// out      | out_valid | out_stall | out_byte, out_last_in_run, out_finished,
//          |           |           | out_bad_distance
// cfg      | cfg_wr_en | -         | cfg_wr_data (output_length)
//
// The parser takes one compressed byte per cycle and queues literals and match
// tokens in a 4-entry command queue; in_stall rises only while that queue is full.
// The copy engine emits a literal at once; a match starts a history RAM read,
// then one byte per cycle from its port (last byte at distance 1) unless stalled.
// Reset (rst_n, synchronous, active low) clears control state only; out_stall holds
// the output register and the engine. After the stop inputs are accepted and dropped.
module lz_flag_word_decompressor #(
  parameter int HISTORY_DEPTH = lzfd_pkg::HISTORY_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_in_run,
  output logic        out_finished,
  output logic        out_bad_distance
);

  lzfd_pkg::cmd_t push_cmd;
  lzfd_pkg::cmd_t pop_cmd;
  logic           q_push;
  logic           q_pop;
  logic           q_valid;
  logic           q_full;

  // Parse stream into commands
  lzfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_stall (in_stall),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  // Decouple parser from copy engine
  lzfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .q_valid  (q_valid),
    .q_full   (q_full)
  );

  // Execute commands against the history window
  lzfd_back #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .q_valid          (q_valid),
    .q_cmd            (pop_cmd),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last_in_run  (out_last_in_run),
    .out_finished     (out_finished),
    .out_bad_distance (out_bad_distance)
  );

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 16;

  typedef enum logic [1:0] {
    DEC_FLAGS,
    DEC_ITEM,
    DEC_TOKEN_LO
  } dec_phase_t;

  typedef enum logic [1:0] {
    STOP_BAD_DISTANCE,
    STOP_CUT_MATCH,
    STOP_ON_LITERAL
  } stop_kind_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       fin;
    logic       bad;
  } out_byte_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        out_last_in_run;
  logic        out_finished;
  logic        out_bad_distance;

  // Decoder state mirrored by the testbench
  logic [31:0] exp_out_length;
  logic [31:0] dec_flag_word;
  logic [4:0]  dec_flags_left;
  logic [1:0]  dec_word_bytes;
  dec_phase_t  dec_phase;
  logic [7:0]  dec_token_hi;
  logic [1:0]  dec_shrink;
  logic [7:0]  dec_history [0:lzfd_pkg::HISTORY_DEPTH-1];
  logic [13:0] dec_wr_pos;
  logic [31:0] dec_count;
  logic        dec_stopped;

  out_byte_t   expected_bytes [$];

  // Stream writer state: flags of the current group still to be used
  logic [1:0]  grp_k;
  logic [29:0] grp_flags;
  int          grp_left;

  int          tx_max_wait;
  int          rx_max_wait;
  int          err_count;
  int          cycle_count;

  lz_flag_word_decompressor uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_last_in_run  (out_last_in_run),
    .out_finished     (out_finished),
    .out_bad_distance (out_bad_distance)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    err_count++;
    $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
  endtask

  function automatic void decoder_reset();
    exp_out_length = 32'd1;
    dec_flag_word  = '0;
    dec_flags_left = '0;
    dec_word_bytes = '0;
    dec_phase      = DEC_FLAGS;
    dec_token_hi   = '0;
    dec_shrink     = '0;
    dec_wr_pos     = '0;
    dec_count      = '0;
    dec_stopped    = 1'b0;
  endfunction

  // Write one byte to the history and queue it as an expected result
  function automatic void produce_byte(input logic [7:0] d, input logic last);
    out_byte_t e;
    dec_history[dec_wr_pos] = d;
    dec_wr_pos = dec_wr_pos + 14'd1;
    dec_count  = dec_count + 32'd1;
    if (dec_count == exp_out_length) dec_stopped = 1'b1;
    e.data = d;
    e.last = last;
    e.fin  = dec_stopped;
    e.bad  = 1'b0;
    expected_bytes.push_back(e);
  endfunction

  function automatic void advance_flag();
    dec_flag_word = dec_flag_word << 1;
    if (dec_flags_left != 0) dec_flags_left = dec_flags_left - 5'd1;
    dec_phase = (dec_flags_left == 0) ? DEC_FLAGS : DEC_ITEM;
  endfunction

  // Expected results of one accepted compressed byte
  function automatic void decompress_byte(input logic [7:0] b);
    logic [15:0] token;
    logic [13:0] dmask;
    logic [13:0] src;
    out_byte_t   e;
    int          distance;
    int          len;
    int          i;
    if (dec_stopped) return;
    case (dec_phase)
      DEC_FLAGS: begin
        dec_flag_word  = {dec_flag_word[23:0], b};
        dec_word_bytes = dec_word_bytes + 2'd1;
        if (dec_word_bytes == 0) begin
          dec_shrink     = dec_flag_word[1:0];
          dec_flags_left = lzfd_pkg::FLAGS_PER_WORD;
          dec_phase      = DEC_ITEM;
        end
      end
      DEC_ITEM: begin
        if (!dec_flag_word[31]) begin
          produce_byte(b, 1'b1);
          if (!dec_stopped) advance_flag();
        end else begin
          dec_token_hi = b;
          dec_phase    = DEC_TOKEN_LO;
        end
      end
      default: begin
        token    = {dec_token_hi, b};
        dmask    = lzfd_pkg::DIST_MASK >> dec_shrink;
        distance = int'(token[13:0] & dmask) + 1;
        len      = int'(token >> (lzfd_pkg::DIST_BITS - dec_shrink))
                   + int'(lzfd_pkg::MIN_MATCH);
        if (distance > dec_count) begin
          // Reach before the first output: one error result, then halt
          dec_stopped = 1'b1;
          e.data = 8'h00;
          e.last = 1'b1;
          e.fin  = 1'b1;
          e.bad  = 1'b1;
          expected_bytes.push_back(e);
        end else begin
          for (i = 0; i < len && !dec_stopped; i++) begin
            src = dec_wr_pos - distance[13:0];
            produce_byte(dec_history[src],
                         (i == len - 1) || (dec_count + 32'd1 == exp_out_length));
          end
          if (!dec_stopped) advance_flag();
        end
      end
    endcase
  endfunction

  // Compare each result taken by the receiver with the oldest expectation
  always @(posedge clk) begin
    out_byte_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch("unexpected result, byte", 32'h0, {24'h0, out_byte});
      end else begin
        e = expected_bytes.pop_front();
        if (out_byte !== e.data) report_mismatch("out_byte", 32'(e.data), 32'(out_byte));
        if (out_last_in_run !== e.last) report_mismatch("out_last_in_run", 32'(e.last),
                                                        32'(out_last_in_run));
        if (out_finished !== e.fin) report_mismatch("out_finished", 32'(e.fin),
                                                    32'(out_finished));
        if (out_bad_distance !== e.bad) report_mismatch("out_bad_distance", 32'(e.bad),
                                                        32'(out_bad_distance));
      end
    end
  end

  // Receiver: hold off each result for a random number of cycles
  initial begin
    int gap;
    out_stall = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      gap = $urandom_range(0, rx_max_wait);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Send one request; valid stays high into the next request when there is no gap
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, tx_max_wait);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    decompress_byte(b);
  endtask

  // Drop valid, wait for every expected result, then let the block settle
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [31:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    exp_out_length = value;
  endtask

  task automatic set_idling(input int tx, input int rx);
    tx_max_wait = tx;
    rx_max_wait = rx;
  endtask

  function automatic int dist_limit(input logic [1:0] k);
    return (int'(lzfd_pkg::DIST_MASK) >> k) + 1;
  endfunction

  function automatic int len_limit(input logic [1:0] k);
    return (1 << (2 + k)) - 1 + int'(lzfd_pkg::MIN_MATCH);
  endfunction

  function automatic logic [29:0] random_flags();
    case ($urandom_range(0, 2))
      0:       return 30'($urandom & $urandom);
      1:       return 30'($urandom);
      default: return 30'($urandom | $urandom);
    endcase
  endfunction

  // Open a group: flag word big-endian, distance shrink in the low two bits
  task automatic start_group(input logic [1:0] k, input logic [29:0] flags);
    logic [31:0] word;
    word = {flags, k};
    send_byte(word[31:24]);
    send_byte(word[23:16]);
    send_byte(word[15:8]);
    send_byte(word[7:0]);
    grp_k     = k;
    grp_flags = flags;
    grp_left  = int'(lzfd_pkg::FLAGS_PER_WORD);
  endtask

  task automatic put_literal(input logic [7:0] b);
    send_byte(b);
    grp_flags = grp_flags << 1;
    grp_left--;
  endtask

  task automatic put_match(input int len, input int distance);
    logic [15:0] token;
    token = 16'(((len - int'(lzfd_pkg::MIN_MATCH)) << (lzfd_pkg::DIST_BITS - grp_k))
                | (distance - 1));
    send_byte(token[15:8]);
    send_byte(token[7:0]);
    grp_flags = grp_flags << 1;
    grp_left--;
  endtask

  // Next item of the stream with random content, valid distance only
  task automatic send_next();
    int dmax;
    int distance;
    int len;
    if (grp_left == 0) start_group(2'($urandom_range(0, 3)), random_flags());
    if (!grp_flags[29]) begin
      put_literal(8'($urandom));
    end else begin
      dmax = dist_limit(grp_k);
      if (dec_count < dmax) dmax = int'(dec_count);
      if ($urandom_range(0, 1)) distance = $urandom_range(1, (dmax > 8) ? 8 : dmax);
      else distance = $urandom_range(1, dmax);
      if ($urandom_range(0, 3) == 0) len = len_limit(grp_k);
      else len = $urandom_range(int'(lzfd_pkg::MIN_MATCH), len_limit(grp_k));
      put_match(len, distance);
    end
  endtask

  task automatic send_random_items(input int count, input bit vary_idling);
    int i;
    for (i = 0; i < count; i++) begin
      if (vary_idling && (i % 10 == 0)) begin
        set_idling($urandom_range(0, 1) ? 18 : 0, $urandom_range(0, 1) ? 18 : 0);
      end
      send_next();
    end
  endtask

  // First group: byte extremes, overlapping copy, longest match, furthest reach
  task automatic test_directed();
    write_length(32'h0000_0000);
    set_idling(18, 18);
    start_group(2'd3, {10'b0010101100, 20'($urandom)});
    put_literal(8'h00);
    put_literal(8'hFF);
    put_match(3, 1);
    put_literal(8'hA5);
    put_match(len_limit(2'd3), 2);
    put_literal(8'h5A);
    put_match(5, int'(dec_count));
    put_match(4, 7);
    put_literal(8'h80);
    put_literal(8'h7F);
  endtask

  task automatic test_max_length_no_idling();
    wait_quiet();
    write_length(32'hFFFF_FFFF);
    set_idling(0, 0);
    send_random_items(30, 1'b0);
  endtask

  // Length below the count: only a 32-bit wrap could reach it
  task automatic test_length_below_count();
    wait_quiet();
    write_length(32'h0000_0001);
    set_idling(18, 18);
    send_random_items(35, 1'b0);
  endtask

  task automatic test_mixed_idling();
    wait_quiet();
    write_length(dec_count + 32'd1000000 + 32'($urandom_range(0, 1 << 30)));
    send_random_items(35, 1'b1);
  endtask

  // End the stream by one of the stop conditions
  task automatic test_stop();
    stop_kind_t  kind;
    logic [1:0]  k;
    logic [29:0] flags;
    int          len;
    int          distance;
    int          cut;
    kind = stop_kind_t'($urandom_range(0, 2));
    if (kind == STOP_BAD_DISTANCE && dec_count >= dist_limit(2'd0)) kind = STOP_CUT_MATCH;
    set_idling(18, 18);
    while (grp_left != 0) send_next();
    k     = 2'($urandom_range(0, 3));
    flags = random_flags();
    case (kind)
      STOP_BAD_DISTANCE: begin
        start_group(2'd0, {1'b1, flags[28:0]});
        put_match($urandom_range(int'(lzfd_pkg::MIN_MATCH), len_limit(2'd0)),
                  $urandom_range(int'(dec_count) + 1, dist_limit(2'd0)));
      end
      STOP_CUT_MATCH: begin
        start_group(k, {1'b1, flags[28:0]});
        len      = $urandom_range(int'(lzfd_pkg::MIN_MATCH), len_limit(k));
        distance = dist_limit(k);
        if (dec_count < distance) distance = int'(dec_count);
        distance = $urandom_range(1, distance);
        cut      = $urandom_range(1, len);
        wait_quiet();
        write_length(dec_count + 32'(cut));
        put_match(len, distance);
      end
      default: begin
        start_group(k, {1'b0, flags[28:0]});
        wait_quiet();
        write_length(dec_count + 32'd1);
        put_literal(8'($urandom));
      end
    endcase
  endtask

  // Once stopped, every request is taken and gives nothing
  task automatic test_after_stop();
    int i;
    for (i = 0; i < 6; i++) send_byte(8'($urandom));
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_byte     = '0;
    err_count   = 0;
    cycle_count = 0;
    grp_left    = 0;
    grp_k       = '0;
    grp_flags   = '0;
    set_idling(0, 0);
    decoder_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_max_length_no_idling();
    test_length_below_count();
    test_mixed_idling();
    test_stop();
    test_after_stop();

    in_valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

>>> lz_flag_word_decompressor.f
hdl/lzfd_pkg.sv
hdl/lzfd_front.sv
hdl/lzfd_queue.sv
hdl/lzfd_back.sv
hdl/lz_flag_word_decompressor.sv
tb/tb.sv
